// ===== design/olid_pkg.sv =====
// ----------------------------------------------------------------------------
// olid_pkg
// Types, codes and defaults shared by the ordered list insert/delete block.
// ----------------------------------------------------------------------------
package olid_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [1:0] CMD_INS_POS   = 2'd0;
    localparam logic [1:0] CMD_DEL_POS   = 2'd1;
    localparam logic [1:0] CMD_INS_MATCH = 2'd2;
    localparam logic [1:0] CMD_DEL_ALL   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_POS   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  position;
        logic [31:0] value;
        logic [31:0] match_value;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  size_now;
        logic [4:0]  slot;
        logic [31:0] element;
        logic        last;
    } t_res;

    typedef struct packed {
        logic       busy;
        logic [6:0] count;
    } t_eng_stat;

endpackage

// ===== design/olid_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// olid_cmd_fifo
// Front end: takes command words and holds them in a two-entry queue
// until the engine picks them up.
// ----------------------------------------------------------------------------
module olid_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  olid_pkg::t_in  i_item,
    output logic           o_full,
    output logic           o_vld,
    output olid_pkg::t_in  o_item,
    input  logic           i_pop
);

    olid_pkg::t_in r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_vld   = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_item;
    end

endmodule

// ===== design/olid_engine.sv =====
// ----------------------------------------------------------------------------
// olid_engine
// Back end: holds the list, runs each command (shift, search, compaction)
// and streams the result words into a one-word output register.
// ----------------------------------------------------------------------------
module olid_engine #(
    parameter int DEPTH     = olid_pkg::DEPTH_DEF,
    parameter int WORD_BITS = olid_pkg::WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_vld,
    input  olid_pkg::t_in       i_job,
    output logic                o_job_pop,
    output logic                o_res_vld,
    output olid_pkg::t_res      o_res,
    input  logic                i_res_pop,
    output olid_pkg::t_eng_stat o_stat
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = (CW > 6) ? CW : 6;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;

    logic [WORD_BITS-1:0] r_list [DEPTH];
    logic [WORD_BITS-1:0] n_list [DEPTH];

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_k, n_k;
    logic [1:0]           r_err, n_err;
    logic                 r_found, n_found;
    logic                 r_del_all, n_del_all;
    logic [WORD_BITS-1:0] r_key, n_key;
    logic [WORD_BITS-1:0] r_val, n_val;
    logic                 r_out_vld, n_out_vld;
    olid_pkg::t_res       r_out, n_out;

    logic [1:0]           sh_op;
    logic [CW-1:0]        sh_at;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] ins_word;
    logic [63:0]          rd_64;
    logic [63:0]          val_64;
    logic [63:0]          match_64;
    logic                 out_free;
    logic                 at_last;
    logic [PW-1:0]        pos_w;
    logic [PW-1:0]        cnt_w;

    assign rd_word  = r_list[r_k[IW-1:0]];
    assign rd_64    = 64'(rd_word);
    assign val_64   = 64'(i_job.value);
    assign match_64 = 64'(i_job.match_value);
    assign out_free = !r_out_vld || i_res_pop;
    assign at_last  = (CW'(r_k + CW'(1)) == r_count);
    assign pos_w    = PW'(i_job.position);
    assign cnt_w    = PW'(r_count);
    // a position insert lands in the pickup cycle, a match insert after the scan
    assign ins_word = (r_state == S_IDLE) ? val_64[WORD_BITS-1:0] : r_val;

    assign o_res_vld   = r_out_vld;
    assign o_res       = r_out;
    assign o_job_pop   = (r_state == S_IDLE) && i_job_vld;
    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.count = 7'(r_count);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_k       = r_k;
        n_err     = r_err;
        n_found   = r_found;
        n_del_all = r_del_all;
        n_key     = r_key;
        n_val     = r_val;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        sh_op     = OP_NONE;
        sh_at     = r_k;

        if (i_res_pop) n_out_vld = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_vld) begin
                    n_val     = val_64[WORD_BITS-1:0];
                    n_key     = (i_job.cmd == olid_pkg::CMD_INS_MATCH) ?
                                match_64[WORD_BITS-1:0] : val_64[WORD_BITS-1:0];
                    n_k       = '0;
                    n_err     = olid_pkg::ST_OK;
                    n_found   = 1'b0;
                    n_del_all = (i_job.cmd == olid_pkg::CMD_DEL_ALL);
                    n_state   = S_EMIT;
                    sh_at     = CW'(i_job.position);
                    unique case (i_job.cmd)
                        olid_pkg::CMD_INS_POS: begin
                            if (pos_w > cnt_w) begin
                                n_err = olid_pkg::ST_BAD_POS;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_err = olid_pkg::ST_FULL;
                            end else begin
                                sh_op   = OP_INS;
                                n_count = r_count + CW'(1);
                            end
                        end
                        olid_pkg::CMD_DEL_POS: begin
                            if (pos_w >= cnt_w) begin
                                n_err = olid_pkg::ST_BAD_POS;
                            end else begin
                                sh_op   = OP_DEL;
                                n_count = r_count - CW'(1);
                            end
                        end
                        default: n_state = S_SCAN;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_k == r_count) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                    if (!r_found) n_err = olid_pkg::ST_NOT_FOUND;
                end else if (rd_word == r_key) begin
                    if (r_del_all) begin
                        // close the gap and look at the same slot again
                        sh_op   = OP_DEL;
                        n_count = r_count - CW'(1);
                        n_found = 1'b1;
                    end else begin
                        n_k     = '0;
                        n_state = S_EMIT;
                        if (r_count == CW'(DEPTH)) begin
                            n_err = olid_pkg::ST_FULL;
                        end else begin
                            sh_op   = OP_INS;
                            sh_at   = r_k + CW'(1);
                            n_count = r_count + CW'(1);
                        end
                    end
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_vld        = 1'b1;
                    n_out.status     = r_err;
                    n_out.size_now   = 6'(r_count);
                    n_out.slot       = '0;
                    n_out.element    = '0;
                    n_out.last       = 1'b1;
                    if (r_err != olid_pkg::ST_OK || r_count == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_out.slot    = 5'(r_k);
                        n_out.element = rd_64[31:0];
                        n_out.last    = at_last;
                        n_k           = r_k + CW'(1);
                        if (at_last) n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // all entries shift at once; entries past the count may take any value
    always_comb begin
        int dn;
        int up;
        for (int i = 0; i < DEPTH; i++) begin
            dn = (i == 0) ? 0 : i - 1;
            up = (i == DEPTH - 1) ? i : i + 1;
            n_list[i] = r_list[i];
            if (sh_op == OP_INS) begin
                if (CW'(i) == sh_at)     n_list[i] = ins_word;
                else if (CW'(i) > sh_at) n_list[i] = r_list[dn];
            end else if (sh_op == OP_DEL) begin
                if (CW'(i) >= sh_at)     n_list[i] = r_list[up];
            end
        end
    end

    // list and job fields need no reset
    always_ff @(posedge i_clk) begin
        r_list    <= n_list;
        r_key     <= n_key;
        r_out     <= n_out;
        r_err     <= n_err;
        r_del_all <= n_del_all;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_k       <= '0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_k       <= n_k;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    // r_val keeps the insert word for a match insert found later in the scan
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ===== design/ordered_list_insert_delete_top.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_top
// Ordered word list with insert/delete by position and by value.
//
//   channel   dir  handshake            word
//   command   in   i_push / o_full      i_item   (olid_pkg::t_in)
//   result    out  o_empty / i_pop      o_result (olid_pkg::t_res)
//
// A position command is applied in its pickup cycle; a value command follows
// the pickup with a search or compaction pass through the list registers.
// Then the list streams out at one word per cycle while results are popped
// (count words, or a single status word). One command at a time.
// Reset empties the list and both queues; list contents are not cleared.
// A stalled result holds the engine; two commands queue ahead of it.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_top #(
    parameter int DEPTH     = olid_pkg::DEPTH_DEF,
    parameter int WORD_BITS = olid_pkg::WORD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  olid_pkg::t_in   i_item,
    output logic            o_full,
    output logic            o_empty,
    output olid_pkg::t_res  o_result,
    input  logic            i_pop
);

    logic                 job_vld;
    logic                 job_pop;
    olid_pkg::t_in        job;
    logic                 res_vld;
    olid_pkg::t_eng_stat  stat;

    olid_cmd_fifo u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .o_vld   (job_vld),
        .o_item  (job),
        .i_pop   (job_pop)
    );

    olid_engine #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (job_vld),
        .i_job     (job),
        .o_job_pop (job_pop),
        .o_res_vld (res_vld),
        .o_res     (o_result),
        .i_res_pop (i_pop),
        .o_stat    (stat)
    );

    assign o_empty = !res_vld;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(stat.count) <= DEPTH)
        else $error("entry count above depth");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.status != olid_pkg::ST_OK) |->
        (o_result.last && o_result.slot == 5'd0 && o_result.element == 32'd0))
        else $error("status word malformed");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.last && i_pop && !stat.busy) |=> o_empty)
        else $error("result word after last");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");
`endif

endmodule

// ===== bench/tb_ordered_list_insert_delete_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_delete_top
// Drives list commands through the input queue, keeps a shadow list that
// predicts every streamed word, and checks each popped word field by field.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_delete_top;

    localparam int LIST_MAX   = olid_pkg::DEPTH_DEF;
    localparam int WDOG_LIMIT = 20000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_push = 1'b0;
    olid_pkg::t_in   i_item = '0;
    logic            o_full;
    logic            o_empty;
    olid_pkg::t_res  o_result;
    logic            i_pop = 1'b0;

    ordered_list_insert_delete_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_item   (i_item),
        .o_full   (o_full),
        .o_empty  (o_empty),
        .o_result (o_result),
        .i_pop    (i_pop)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the list held by the block
    logic [31:0]    shadow_list[LIST_MAX];
    int             shadow_count;
    olid_pkg::t_res pending_words[$];

    int n_cmds;
    int n_words;
    int n_mismatch;
    int n_errs_seen;
    int idle_cycles = 0;
    bit hold_off;

    // sender burst shaping
    int burst_left;

    function automatic void push_status(logic [1:0] code);
        olid_pkg::t_res r;
        r = '0;
        r.status = code;
        r.size_now = shadow_count[5:0];
        r.last = 1'b1;
        pending_words.push_back(r);
        if (code != olid_pkg::ST_OK) n_errs_seen++;
    endfunction

    function automatic void push_listing();
        olid_pkg::t_res r;
        if (shadow_count == 0) begin
            push_status(olid_pkg::ST_OK);
            return;
        end
        for (int k = 0; k < shadow_count; k++) begin
            r = '0;
            r.status = olid_pkg::ST_OK;
            r.size_now = shadow_count[5:0];
            r.slot = k[4:0];
            r.element = shadow_list[k];
            r.last = (k + 1 == shadow_count);
            pending_words.push_back(r);
        end
    endfunction

    function automatic void open_slot(int at, logic [31:0] w);
        for (int k = shadow_count; k > at; k--) shadow_list[k] = shadow_list[k - 1];
        shadow_list[at] = w;
        shadow_count++;
    endfunction

    function automatic void predict_list_cmd(olid_pkg::t_in c);
        int k;
        int w;
        case (c.cmd)
            olid_pkg::CMD_INS_POS: begin
                if (int'(c.position) > shadow_count) push_status(olid_pkg::ST_BAD_POS);
                else if (shadow_count >= LIST_MAX) push_status(olid_pkg::ST_FULL);
                else begin
                    open_slot(int'(c.position), c.value);
                    push_listing();
                end
            end
            olid_pkg::CMD_DEL_POS: begin
                if (int'(c.position) >= shadow_count) push_status(olid_pkg::ST_BAD_POS);
                else begin
                    for (k = int'(c.position); k + 1 < shadow_count; k++)
                        shadow_list[k] = shadow_list[k + 1];
                    shadow_count--;
                    push_listing();
                end
            end
            olid_pkg::CMD_INS_MATCH: begin
                for (k = 0; k < shadow_count; k++)
                    if (shadow_list[k] == c.match_value) break;
                if (k >= shadow_count) push_status(olid_pkg::ST_NOT_FOUND);
                else if (shadow_count >= LIST_MAX) push_status(olid_pkg::ST_FULL);
                else begin
                    open_slot(k + 1, c.value);
                    push_listing();
                end
            end
            default: begin
                w = 0;
                for (k = 0; k < shadow_count; k++)
                    if (shadow_list[k] != c.value) begin
                        shadow_list[w] = shadow_list[k];
                        w++;
                    end
                if (w == shadow_count) push_status(olid_pkg::ST_NOT_FOUND);
                else begin
                    shadow_count = w;
                    push_listing();
                end
            end
        endcase
    endfunction

    // sends one command word; bursts and gaps are shaped here
    // entered and left at a falling edge; push stays high inside a burst
    task automatic send_cmd(olid_pkg::t_in c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
            if (gap != 0) begin
                i_push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        i_item <= c;
        i_push <= 1'b1;
        while (o_full) @(negedge i_clk);
        @(posedge i_clk);
        predict_list_cmd(c);
        n_cmds++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic drain_all();
        i_push <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
    endtask

    function automatic olid_pkg::t_in mk(logic [1:0] op, int pos, logic [31:0] v,
                                         logic [31:0] m);
        olid_pkg::t_in c;
        c.cmd = op;
        c.position = pos[5:0];
        c.value = v;
        c.match_value = m;
        return c;
    endfunction

    // values drawn from a small pool so that matches happen often
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 3))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0;
            default: return 32'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [31:0] pick_listed();
        if (shadow_count == 0 || $urandom_range(0, 4) == 0) return $urandom;
        return shadow_list[$urandom_range(0, shadow_count - 1)];
    endfunction

    task automatic test_edges();
        send_cmd(mk(olid_pkg::CMD_DEL_POS, 0, 32'h0, 32'h0));           // delete on empty
        send_cmd(mk(olid_pkg::CMD_INS_POS, 1, 32'h1, 32'h0));           // past the end
        send_cmd(mk(olid_pkg::CMD_INS_MATCH, 0, 32'h5, 32'h5));         // no match
        send_cmd(mk(olid_pkg::CMD_DEL_ALL, 0, 32'h5, 32'h0));           // no match
        send_cmd(mk(olid_pkg::CMD_INS_POS, 0, 32'hFFFF_FFFF, 32'h0));
        send_cmd(mk(olid_pkg::CMD_INS_POS, 1, 32'h0, 32'h0));           // append
        send_cmd(mk(olid_pkg::CMD_INS_POS, 0, 32'hAAAA_5555, 32'h0));   // front
        send_cmd(mk(olid_pkg::CMD_INS_MATCH, 0, 32'h5555_AAAA, 32'hFFFF_FFFF));
        send_cmd(mk(olid_pkg::CMD_INS_POS, 63, 32'h1, 32'h0));          // position all ones
        send_cmd(mk(olid_pkg::CMD_DEL_POS, 4, 32'h0, 32'h0));           // at count
        send_cmd(mk(olid_pkg::CMD_DEL_POS, 3, 32'h0, 32'h0));           // last entry
        send_cmd(mk(olid_pkg::CMD_DEL_POS, 0, 32'h0, 32'h0));
        send_cmd(mk(olid_pkg::CMD_DEL_ALL, 0, 32'hFFFF_FFFF, 32'h0));
        send_cmd(mk(olid_pkg::CMD_DEL_ALL, 0, 32'h5555_AAAA, 32'h0));   // empties list
    endtask

    task automatic test_fill_to_full();
        while (shadow_count < LIST_MAX)
            send_cmd(mk(olid_pkg::CMD_INS_POS, shadow_count,
                        $urandom_range(0, 1) ? 32'h7 : $urandom, 32'h0));
        send_cmd(mk(olid_pkg::CMD_INS_POS, 32, 32'h9, 32'h0));          // full, position ok
        send_cmd(mk(olid_pkg::CMD_INS_POS, 33, 32'h9, 32'h0));          // bad position wins
        send_cmd(mk(olid_pkg::CMD_INS_MATCH, 0, 32'h9, shadow_list[5])); // full after match
        send_cmd(mk(olid_pkg::CMD_INS_MATCH, 0, 32'h9, 32'hDEAD_0001)); // miss wins over full
        send_cmd(mk(olid_pkg::CMD_DEL_POS, 31, 32'h0, 32'h0));
        send_cmd(mk(olid_pkg::CMD_DEL_ALL, 0, 32'h7, 32'h0));
    endtask

    task automatic test_random(int count);
        olid_pkg::t_in c;
        for (int n = 0; n < count; n++) begin
            c.cmd = 2'($urandom_range(0, 3));
            // grow the list more often than it shrinks while it is short
            if (shadow_count < 6 && $urandom_range(0, 2) != 0)
                c.cmd = $urandom_range(0, 1) ? olid_pkg::CMD_INS_POS
                                             : olid_pkg::CMD_INS_MATCH;
            c.position = ($urandom_range(0, 9) == 0) ? 6'($urandom)
                         : 6'($urandom_range(0, shadow_count));
            c.value = ($urandom_range(0, 7) == 0) ? $urandom : pick_word();
            if (c.cmd == olid_pkg::CMD_DEL_ALL && $urandom_range(0, 3) != 0)
                c.value = pick_listed();
            c.match_value = pick_listed();
            send_cmd(c);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random(10);
        hold_off = 1'b0;
        drain_all();
        repeat (5) @(negedge i_clk);
    endtask

    // receiver: own stall pattern, plus a long hold-off counted here
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_pop <= 1'b0;
                repeat (300) @(negedge i_clk);
                while (hold_off && o_full == 1'b0) @(negedge i_clk);
                hold_off = 1'b0;
            end
            phase++;
            if (phase % 200 < 60) i_pop <= 1'b1;
            else i_pop <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        olid_pkg::t_res exp_w;
        if (i_rst_n && i_pop && !o_empty) begin
            n_words++;
            if (pending_words.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected word %p", o_result);
            end else begin
                exp_w = pending_words.pop_front();
                if (o_result.status !== exp_w.status || o_result.size_now !== exp_w.size_now
                    || o_result.slot !== exp_w.slot || o_result.element !== exp_w.element
                    || o_result.last !== exp_w.last) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("word mismatch: exp %p got %p", exp_w, o_result);
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        n_cmds = 0;
        n_words = 0;
        n_mismatch = 0;
        n_errs_seen = 0;
        shadow_count = 0;
        burst_left = 0;
        hold_off = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_edges();
        test_fill_to_full();
        drain_all();
        test_backpressure();
        test_random(120);
        drain_all();
        repeat (40) @(negedge i_clk);
        test_random(140);
        drain_all();
        repeat (40) @(negedge i_clk);
        if (i_pop && !o_empty) n_mismatch++;
        $display("Ran %0d list commands, checked %0d result words (%0d error statuses).",
                 n_cmds, n_words, n_errs_seen);
        $display("Covered empty, full, bad position, miss, delete-all and back-pressure.");
        if (n_mismatch == 0 && pending_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
